// ----- hw/rtl/alphabet_random_symbol_drawer_defines.svh -----
// Assertion macros shared by the symbol drawer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ALPHABET_RANDOM_SYMBOL_DRAWER_DEFINES_SVH
`define ALPHABET_RANDOM_SYMBOL_DRAWER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ards_pkg.sv -----
// Package for the alphabet random symbol drawer: widths, codes, constants, types.
// No dependencies.
`timescale 1ns / 1ps

package ards_pkg;

    localparam int unsigned SYMBOL_VALUES_DEF = 256;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned SIZE_W     = 9;
    localparam int unsigned GEN_W      = 31;
    localparam int unsigned MULB_W     = 15;
    localparam int unsigned PROD_W     = GEN_W + MULB_W;
    localparam int unsigned CHUNK_W    = 32;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned PC_W       = 6;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 31;

    // opcodes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL_NUL = 1'd1;

    // Park-Miller minimal standard generator
    localparam logic [GEN_W-1:0]  LCG_MOD    = 31'h7FFF_FFFF;
    localparam logic [MULB_W-1:0] LCG_MULT   = 15'd16807;
    localparam logic [GEN_W-1:0]  SEED_RESET = 31'd1;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  pos;
        logic [PC_W-1:0]   count;
    } t_scan_res;

    typedef struct packed {
        logic [GEN_W-1:0]  rem;
        logic [MULB_W:0]   quot;
    } t_fold_res;

endpackage

// ----- hw/rtl/ards_in_if.sv -----
// Input channel of the symbol drawer: valid/ready plus opcode and text byte.
// Depends on ards_pkg.
`timescale 1ns / 1ps

interface ards_in_if;
    logic                          valid;
    logic                          ready;
    logic [ards_pkg::OP_W-1:0]     opcode;
    logic [ards_pkg::BYTE_W-1:0]   text_byte;

    modport source (output valid, output opcode, output text_byte, input ready);
    modport sink   (input valid, input opcode, input text_byte, output ready);
endinterface

// ----- hw/rtl/ards_out_if.sv -----
// Result channel of the symbol drawer: valid/ready plus symbol, size and error.
// Depends on ards_pkg.
`timescale 1ns / 1ps

interface ards_out_if;
    logic                          valid;
    logic                          ready;
    logic [ards_pkg::BYTE_W-1:0]   symbol;
    logic [ards_pkg::SIZE_W-1:0]   alphabet_size;
    logic                          empty_error;

    modport source (output valid, output symbol, output alphabet_size,
                    output empty_error, input ready);
    modport sink   (input valid, input symbol, input alphabet_size,
                    input empty_error, output ready);
endinterface

// ----- hw/rtl/ards_arith.sv -----
// Shared arithmetic unit: registered 31x15 multiply, then fold modulo 2^31-1.
// Depends on ards_pkg.
`timescale 1ns / 1ps

module ards_arith (
    input  logic                          i_clk,
    input  logic [ards_pkg::GEN_W-1:0]    i_a,
    input  logic [ards_pkg::MULB_W-1:0]   i_b,
    output ards_pkg::t_fold_res           o_fold
);
    import ards_pkg::*;

    logic [PROD_W-1:0]  r_prod;
    logic [MULB_W-1:0]  w_hi;
    logic [GEN_W-1:0]   w_lo;
    logic [GEN_W:0]     w_sum;
    logic               w_ge;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    // x = hi*2^31 + lo = hi*M + (hi + lo); hi + lo < 2M so one subtract fixes it
    assign w_hi  = r_prod[PROD_W-1:GEN_W];
    assign w_lo  = r_prod[GEN_W-1:0];
    assign w_sum = (GEN_W+1)'(w_hi) + (GEN_W+1)'(w_lo);
    assign w_ge  = (w_sum >= {1'b0, LCG_MOD});

    assign o_fold.rem  = w_ge ? GEN_W'(w_sum - {1'b0, LCG_MOD}) : w_sum[GEN_W-1:0];
    assign o_fold.quot = (MULB_W+1)'(w_hi) + (MULB_W+1)'(w_ge);

endmodule

// ----- hw/rtl/ards_rank_scan.sv -----
// Rank select over one 32-bit chunk of the presence map.
// Depends on ards_pkg.
`timescale 1ns / 1ps

module ards_rank_scan (
    input  logic [ards_pkg::CHUNK_W-1:0]  i_chunk,
    input  logic [ards_pkg::SIZE_W-1:0]   i_rank,
    output ards_pkg::t_scan_res           o_res
);
    import ards_pkg::*;

    logic [CHUNK_W-1:0] w_below;
    logic [PC_W-1:0]    w_prefix;
    logic               w_found;
    logic [POS_W-1:0]   w_pos;

    // at most one set bit has exactly i_rank set bits below it
    always_comb begin
        w_found  = 1'b0;
        w_pos    = '0;
        w_below  = '0;
        w_prefix = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            w_below  = i_chunk & ((CHUNK_W'(1) << j) - CHUNK_W'(1));
            w_prefix = PC_W'($countones(w_below));
            if (i_chunk[j] && (SIZE_W'(w_prefix) == i_rank)) begin
                w_found = 1'b1;
                w_pos   = w_pos | POS_W'(j);
            end
        end
    end

    assign o_res.found = w_found;
    assign o_res.pos   = w_pos;
    assign o_res.count = PC_W'($countones(i_chunk));

endmodule

// ----- hw/rtl/alphabet_random_symbol_drawer.sv -----
// Top level of the alphabet random symbol drawer: sequencer, presence map, config.
// Depends on ards_pkg, ards_in_if, ards_out_if, ards_arith, ards_rank_scan and the defines header.
`timescale 1ns / 1ps
`include "alphabet_random_symbol_drawer_defines.svh"

// Learns the byte alphabet of a text and draws random symbols from it. Every
// input transfer (clear, add, draw, or the unused code which only reports
// state) yields exactly one result transfer. The block handles one item at a
// time and drops i_in.ready from acceptance until the result is loaded into
// the output register; a finished result may wait there while the next item
// is taken. Clear and add go from S_EXEC through S_FIN into the output
// register, as does a draw on an empty alphabet. A draw runs the shared
// multiply/fold unit twice (generator step x*16807 mod 2^31-1, then the
// scaled index floor(x*size/(2^31-1))) in S_EXEC, S_RED1, S_MUL2 and
// S_RED2, then walks the presence map in S_SCAN in 32-bit chunks, one
// chunk per cycle, up to the chunk holding the wanted rank, and ends in
// S_FIN. The presence map lives in flops and is cleared at once, both by
// reset and by the clear operation. A zero seed, or a seed equal to the
// modulus, loads 1. Config writes are taken any time but are meant for an
// idle block.
module alphabet_random_symbol_drawer #(
    parameter int unsigned SYMBOL_VALUES = ards_pkg::SYMBOL_VALUES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ards_in_if.sink                           i_in,
    ards_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [ards_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ards_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ards_pkg::*;

    localparam int unsigned NUM_CHUNKS  = (SYMBOL_VALUES + CHUNK_W - 1) / CHUNK_W;
    localparam int unsigned CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int unsigned PAD_W       = (2 ** CHUNK_IDX_W) * CHUNK_W;
    localparam int unsigned MAP_IDX_W   = $clog2(SYMBOL_VALUES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RED1,
        S_MUL2,
        S_RED2,
        S_SCAN,
        S_FIN
    } t_state;

    // control
    t_state                   r_fsm,       n_fsm;
    logic [SYMBOL_VALUES-1:0] r_map,       n_map;
    logic [SIZE_W-1:0]        r_count,     n_count;
    logic [GEN_W-1:0]         r_gen,       n_gen;
    logic [GEN_W-1:0]         r_seed;
    logic                     r_excl;
    logic                     r_out_valid, n_out_valid;
    // payload
    logic [OP_W-1:0]          r_op,        n_op;
    logic [BYTE_W-1:0]        r_byte,      n_byte;
    logic [SIZE_W-1:0]        r_rank,      n_rank;
    logic [CHUNK_IDX_W-1:0]   r_chunk,     n_chunk;
    logic [BYTE_W-1:0]        r_sym,       n_sym;
    logic                     r_err,       n_err;
    logic [BYTE_W-1:0]        r_out_sym,   n_out_sym;
    logic [SIZE_W-1:0]        r_out_size,  n_out_size;
    logic                     r_out_err,   n_out_err;

    logic [GEN_W-1:0]         w_mul_a;
    logic [MULB_W-1:0]        w_mul_b;
    t_fold_res                w_fold;
    t_scan_res                w_scan;
    logic [PAD_W-1:0]         w_map_pad;
    logic                     w_skip;
    logic [MAP_IDX_W-1:0]     w_idx;

    // shared unit: generator step in S_EXEC, scaled index in S_MUL2
    assign w_mul_a = r_gen;
    assign w_mul_b = (r_fsm == S_MUL2) ? MULB_W'(r_count) : LCG_MULT;

    ards_arith u_arith (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_fold (w_fold)
    );

    assign w_map_pad = PAD_W'(r_map);

    ards_rank_scan u_scan (
        .i_chunk (w_map_pad[r_chunk*CHUNK_W +: CHUNK_W]),
        .i_rank  (r_rank),
        .o_res   (w_scan)
    );

    assign w_idx  = r_byte[MAP_IDX_W-1:0];
    assign w_skip = ((r_byte == '0) && r_excl)
                 || (SIZE_W'(r_byte) >= SIZE_W'(SYMBOL_VALUES));

    assign i_in.ready          = (r_fsm == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.symbol        = r_out_sym;
    assign o_out.alphabet_size = r_out_size;
    assign o_out.empty_error   = r_out_err;

    always_comb begin
        n_fsm       = r_fsm;
        n_map       = r_map;
        n_count     = r_count;
        n_gen       = r_gen;
        n_op        = r_op;
        n_byte      = r_byte;
        n_rank      = r_rank;
        n_chunk     = r_chunk;
        n_sym       = r_sym;
        n_err       = r_err;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_sym   = r_out_sym;
        n_out_size  = r_out_size;
        n_out_err   = r_out_err;

        case (r_fsm)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op   = i_in.opcode;
                    n_byte = i_in.text_byte;
                    n_fsm  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_sym = '0;
                n_err = 1'b0;
                n_fsm = S_FIN;
                case (r_op)
                    OP_CLEAR: begin
                        n_map   = '0;
                        n_count = '0;
                        n_gen   = ((r_seed == '0) || (r_seed == LCG_MOD)) ? SEED_RESET : r_seed;
                    end
                    OP_ADD: begin
                        if (!w_skip && !r_map[w_idx]) begin
                            n_map[w_idx] = 1'b1;
                            n_count      = r_count + SIZE_W'(1);
                        end
                    end
                    OP_DRAW: begin
                        // product r_gen*16807 is captured at this edge
                        if (r_count == '0) begin
                            n_err = 1'b1;
                        end else begin
                            n_fsm = S_RED1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RED1: begin
                n_gen = w_fold.rem;
                n_fsm = S_MUL2;
            end
            S_MUL2: begin
                n_fsm = S_RED2;
            end
            S_RED2: begin
                n_rank  = w_fold.quot[SIZE_W-1:0];
                n_chunk = '0;
                n_fsm   = S_SCAN;
            end
            S_SCAN: begin
                if (w_scan.found) begin
                    n_sym = BYTE_W'({r_chunk, w_scan.pos});
                    n_fsm = S_FIN;
                end else begin
                    n_rank  = r_rank - SIZE_W'(w_scan.count);
                    n_chunk = r_chunk + CHUNK_IDX_W'(1);
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = r_sym;
                    n_out_size  = r_count;
                    n_out_err   = r_err;
                    n_fsm       = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_map       <= '0;
            r_count     <= '0;
            r_gen       <= SEED_RESET;
            r_seed      <= SEED_RESET;
            r_excl      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_map       <= n_map;
            r_count     <= n_count;
            r_gen       <= n_gen;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SEED:     r_seed <= i_cfg_data[GEN_W-1:0];
                    CFG_EXCL_NUL: r_excl <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        r_op       <= n_op;
        r_byte     <= n_byte;
        r_rank     <= n_rank;
        r_chunk    <= n_chunk;
        r_sym      <= n_sym;
        r_err      <= n_err;
        r_out_sym  <= n_out_sym;
        r_out_size <= n_out_size;
        r_out_err  <= n_out_err;
    end

    // checks
    `ARDS_ASSERT_NOW(a_count_matches_map, i_clk, i_rst_n, 1'b1, (32'(r_count) == $countones(r_map)), "symbol count out of step with presence map")
    `ARDS_ASSERT_NOW(a_gen_in_range, i_clk, i_rst_n, 1'b1, ((r_gen != '0) && (r_gen != LCG_MOD)), "generator state left 1 .. 2^31-2")
    `ARDS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, (i_in.valid && i_in.ready), !i_in.ready, "input taken while an item is in work")

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the alphabet random symbol drawer.
// Needs ards_pkg, ards_in_if, ards_out_if and the alphabet_random_symbol_drawer RTL.
`timescale 1ns / 1ps

import ards_pkg::*;

// The one opcode value the block does not use; it only reports state
localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic [SIZE_W-1:0] alphabet_size;
    logic              empty_error;
} t_alphabet_result;

// Tracks the alphabet and generator, and queues the result of every
// accepted item until the block returns it.
class alphabet_tracker;
    bit [SYMBOL_VALUES_DEF-1:0] present;
    bit [SIZE_W-1:0]            n_symbols;
    bit [GEN_W-1:0]             lcg;
    bit [GEN_W-1:0]             seed_reg;
    bit                         excl_nul_reg;
    t_alphabet_result           pending_results[$];
    int unsigned                mismatches;
    int unsigned                n_clears, n_adds, n_draws, n_empty_draws;
    int unsigned                n_full_draws, n_unused;

    function new();
        present      = '0;
        n_symbols    = '0;
        lcg          = SEED_RESET;
        seed_reg     = SEED_RESET;
        excl_nul_reg = 1'b1;
        mismatches   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SEED:     seed_reg = data[GEN_W-1:0];
            CFG_EXCL_NUL: excl_nul_reg = data[0];
            default: ;
        endcase
    endfunction

    // seed equal to the modulus folds to zero, and zero loads one
    function bit [GEN_W-1:0] seed_to_state(bit [GEN_W-1:0] s);
        longint unsigned v;
        v = 64'(s) % 64'(LCG_MOD);
        return (v == 0) ? GEN_W'(1) : GEN_W'(v);
    endfunction

    function bit [BYTE_W-1:0] symbol_of_rank(longint unsigned rank);
        longint unsigned seen;
        seen = 0;
        for (int i = 0; i < SYMBOL_VALUES_DEF; i++) begin
            if (present[i]) begin
                if (seen == rank) return BYTE_W'(i);
                seen++;
            end
        end
        return '0;
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
        t_alphabet_result r;
        longint unsigned  scaled;
        r = '0;
        case (op)
            OP_CLEAR: begin
                present   = '0;
                n_symbols = '0;
                lcg       = seed_to_state(seed_reg);
                n_clears++;
            end
            OP_ADD: begin
                n_adds++;
                if (!(b == 0 && excl_nul_reg) && !present[b]) begin
                    present[b] = 1'b1;
                    n_symbols++;
                end
            end
            OP_DRAW: begin
                if (n_symbols == 0) begin
                    // empty map: flag only, generator holds
                    r.empty_error = 1'b1;
                    n_empty_draws++;
                end else begin
                    lcg      = GEN_W'((64'(lcg) * 64'(LCG_MULT)) % 64'(LCG_MOD));
                    scaled   = (64'(lcg) * 64'(n_symbols)) / 64'(LCG_MOD);
                    r.symbol = symbol_of_rank(scaled);
                    n_draws++;
                    if (n_symbols == SIZE_W'(SYMBOL_VALUES_DEF)) n_full_draws++;
                end
            end
            default: n_unused++;
        endcase
        r.alphabet_size = n_symbols;
        pending_results.push_back(r);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    task check_result(t_alphabet_result got);
        t_alphabet_result want;
        if (pending_results.size() == 0) begin
            report("result with nothing pending, symbol", got.symbol, 0);
        end else begin
            want = pending_results.pop_front();
            if (got.symbol !== want.symbol)
                report("symbol", got.symbol, want.symbol);
            if (got.alphabet_size !== want.alphabet_size)
                report("alphabet_size", got.alphabet_size, want.alphabet_size);
            if (got.empty_error !== want.empty_error)
                report("empty_error", got.empty_error, want.empty_error);
        end
    endtask
endclass

module tb_top;

    // Worst item: its time in the block, the longest receiver stall and the
    // longest sender gap; a thousand items fit many times in this limit.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ITEMS_PER_PHASE = 65;
    localparam int unsigned N_PHASES = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ards_in_if  in_ch ();
    ards_out_if out_ch ();

    alphabet_random_symbol_drawer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    alphabet_tracker book = new();

    int unsigned cycle_count = 0;
    int unsigned sent_items  = 0;
    int unsigned burst_left  = 0;
    int unsigned stall_left  = 0;

    always #1 i_clk = ~i_clk;

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit reached with %0d results pending",
                     book.pending_results.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Receiver back-pressure. The mode rotates with bits of the cycle counter:
    // always ready, short random stalls, rare long stalls, or a counter bit.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            out_ch.ready = 1'b0;
            stall_left--;
        end else begin
            out_ch.ready = 1'b1;
            case (cycle_count[10:9])
                2'd0: ;
                2'd1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
                2'd2: if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 20);
                default: out_ch.ready = cycle_count[1];
            endcase
        end
    end

    // Result monitor: inputs settle at the falling edge, so values seen at the
    // rising edge are the ones the block transfers.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            book.check_result('{symbol:        out_ch.symbol,
                                alphabet_size: out_ch.alphabet_size,
                                empty_error:   out_ch.empty_error});
    end

    // Offer one item and hold it until the transfer. Called at a falling edge
    // and returns at one. Valid stays high across back-to-back items inside a
    // burst; a gap of random length opens most new bursts.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
        if (burst_left == 0) begin
            in_ch.valid = 1'b0;
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid     = 1'b1;
        in_ch.opcode    = op;
        in_ch.text_byte = b;
        do @(posedge i_clk); while (!in_ch.ready);
        book.note_item(op, b);
        sent_items++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every pending result; each item has a
    // result, so a short tail is enough for the block to return to idle.
    task automatic drain_results();
        in_ch.valid = 1'b0;
        burst_left  = 0;
        while (book.pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        book.set_register(idx, data);
    endtask

    // Mostly spread over the byte range, with a bias toward the two extremes
    // and a narrow band so repeated adds happen.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 15));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [GEN_W-1:0] seed_tab [N_PHASES];
        bit               excl_tab [N_PHASES];
        int unsigned      phase_end;
        int unsigned      choice;
        int unsigned      n;
        logic [BYTE_W-1:0] offset;
        bit               filled;

        in_ch.valid     = 1'b0;
        in_ch.opcode    = OP_CLEAR;
        in_ch.text_byte = '0;
        out_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_SEED;
        cfg_data        = '0;
        i_rst_n         = 1'b0;
        filled          = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part, reset config: seed 1, nul excluded ----
        send_item(OP_DRAW, 8'd0);       // draw on the empty map after reset
        send_item(OP_UNUSED, 8'd255);   // unused code only reports state
        send_item(OP_ADD, 8'd0);        // nul is kept out
        send_item(OP_ADD, 8'd255);
        send_item(OP_ADD, 8'd255);      // repeated byte
        send_item(OP_DRAW, 8'd0);       // single symbol, must be 255
        send_item(OP_ADD, 8'd1);
        send_item(OP_ADD, 8'd128);
        repeat (3) send_item(OP_DRAW, 8'd0);
        send_item(OP_CLEAR, 8'd77);
        send_item(OP_DRAW, 8'd0);       // empty again after clear
        drain_results();

        // zero seed loads one; nul allowed
        write_register(CFG_SEED, '0);
        write_register(CFG_EXCL_NUL, 31'd0);
        send_item(OP_CLEAR, 8'd0);
        send_item(OP_ADD, 8'd0);
        send_item(OP_ADD, 8'd255);
        repeat (2) send_item(OP_DRAW, 8'd0);
        drain_results();

        // nul excluded again: the nul added earlier stays present
        write_register(CFG_EXCL_NUL, 31'd1);
        send_item(OP_ADD, 8'd0);
        send_item(OP_DRAW, 8'd0);
        drain_results();

        // seed equal to the modulus folds to zero and loads one
        write_register(CFG_SEED, 31'h7FFF_FFFF);
        send_item(OP_CLEAR, 8'd0);
        send_item(OP_ADD, 8'd7);
        repeat (2) send_item(OP_DRAW, 8'd0);

        // ---- random part, one config setting per phase ----
        seed_tab[0] = 31'd1;          excl_tab[0] = 1'b1;
        seed_tab[1] = 31'd0;          excl_tab[1] = 1'b1;
        seed_tab[2] = 31'h7FFF_FFFF;  excl_tab[2] = 1'b0;   // full map here
        seed_tab[3] = 31'h7FFF_FFFE;  excl_tab[3] = 1'b0;
        for (int p = 4; p < N_PHASES; p++) begin
            seed_tab[p] = 31'($urandom());
            excl_tab[p] = 1'($urandom_range(0, 1));
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            write_register(CFG_SEED, seed_tab[p]);
            write_register(CFG_EXCL_NUL, {30'd0, excl_tab[p]});
            phase_end = sent_items + ITEMS_PER_PHASE;
            while (sent_items < phase_end) begin
                choice = $urandom_range(0, 11);
                if (choice < 8) begin
                    // well-formed: clear, build an alphabet, draw from it
                    send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
                    if (p == 2 && !filled) begin
                        // every byte value once, in scrambled order
                        offset = 8'($urandom_range(0, 255));
                        for (int i = 0; i < SYMBOL_VALUES_DEF; i++)
                            send_item(OP_ADD, 8'(i) ^ offset);
                        filled = 1'b1;
                    end else begin
                        n = $urandom_range(1, 20);
                        repeat (n) send_item(OP_ADD, pick_byte());
                    end
                    n = $urandom_range(1, 12);
                    repeat (n) begin
                        if ($urandom_range(0, 4) == 0) send_item(OP_ADD, pick_byte());
                        else send_item(OP_DRAW, 8'($urandom_range(0, 255)));
                    end
                end else if (choice < 10) begin
                    // noise: any code, any byte
                    n = $urandom_range(1, 4);
                    repeat (n) send_item(OP_OP_PICK(), 8'($urandom_range(0, 255)));
                end else if (choice == 10) begin
                    send_item(OP_CLEAR, 8'd0);
                    send_item(OP_DRAW, 8'd0);
                end else begin
                    drain_results();      // sender waits for all results
                end
            end
        end

        drain_results();
        repeat (20) @(negedge i_clk);

        $display("ran %0d items over %0d config phases: %0d clears, %0d adds, %0d unused codes",
                 sent_items, N_PHASES, book.n_clears, book.n_adds, book.n_unused);
        $display("draws: %0d from a filled map (%0d with all 256 symbols), %0d on an empty map",
                 book.n_draws, book.n_full_draws, book.n_empty_draws);
        if (book.mismatches == 0 && book.pending_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Random opcode over all four codes for the noise items
    function automatic logic [OP_W-1:0] OP_OP_PICK();
        case ($urandom_range(0, 3))
            0:       return OP_CLEAR;
            1:       return OP_ADD;
            2:       return OP_DRAW;
            default: return OP_UNUSED;
        endcase
    endfunction

endmodule
